// File: rtl/core/mcl3_pkg.sv
// Shared types and constants for the Cl(3,0) multivector accumulator ALU.
// Holds the item structs, opcodes, component limits and the blade product table.
// No dependencies; every other file imports it.
package mcl3_pkg;

  localparam int CompWidth = 16;
  localparam int FracBits  = 8;
  localparam int NumBlades = 8;
  localparam int OpW       = 3;

  typedef logic signed [CompWidth-1:0] comp_t;
  typedef comp_t [NumBlades-1:0] mvec_t;

  localparam logic signed [CompWidth-1:0] CompMax = {1'b0, {(CompWidth-1){1'b1}}};
  localparam logic signed [CompWidth-1:0] CompMin = {1'b1, {(CompWidth-1){1'b0}}};

  // Opcodes
  localparam logic [OpW-1:0] OpLoad    = 3'd0;
  localparam logic [OpW-1:0] OpAdd     = 3'd1;
  localparam logic [OpW-1:0] OpGeoProd = 3'd2;
  localparam logic [OpW-1:0] OpReverse = 3'd3;
  localparam logic [OpW-1:0] OpNear    = 3'd4;

  // Blades negated by reverse: e12, e13, e23, e123
  localparam logic [NumBlades-1:0] RevMask = 8'b1110_1000;

  // Product of blade i by blade j: magnitude is destination blade plus one,
  // sign gives the sign of the term
  localparam logic signed [4:0] BladeTable [NumBlades][NumBlades] = '{
    '{ 5'sd1,  5'sd2,  5'sd3,  5'sd4,  5'sd5,  5'sd6,  5'sd7,  5'sd8},
    '{ 5'sd2,  5'sd1,  5'sd4,  5'sd3,  5'sd6,  5'sd5,  5'sd8,  5'sd7},
    '{ 5'sd3, -5'sd4,  5'sd1, -5'sd2,  5'sd7, -5'sd8,  5'sd5, -5'sd6},
    '{ 5'sd4, -5'sd3,  5'sd2, -5'sd1,  5'sd8, -5'sd7,  5'sd6, -5'sd5},
    '{ 5'sd5, -5'sd6, -5'sd7,  5'sd8,  5'sd1, -5'sd2, -5'sd3,  5'sd4},
    '{ 5'sd6, -5'sd5, -5'sd8,  5'sd7,  5'sd2, -5'sd1, -5'sd4,  5'sd3},
    '{ 5'sd7,  5'sd8, -5'sd5, -5'sd6,  5'sd3,  5'sd4, -5'sd1, -5'sd2},
    '{ 5'sd8,  5'sd7, -5'sd6, -5'sd5,  5'sd4,  5'sd3, -5'sd2, -5'sd1}
  };

  typedef struct packed {
    logic [OpW-1:0]             op;
    logic signed [CompWidth-1:0] x_scalar;
    logic signed [CompWidth-1:0] x_e1;
    logic signed [CompWidth-1:0] x_e2;
    logic signed [CompWidth-1:0] x_e12;
    logic signed [CompWidth-1:0] x_e3;
    logic signed [CompWidth-1:0] x_e13;
    logic signed [CompWidth-1:0] x_e23;
    logic signed [CompWidth-1:0] x_e123;
  } in_item_t;

  typedef struct packed {
    logic signed [CompWidth-1:0] acc_scalar;
    logic signed [CompWidth-1:0] acc_e1;
    logic signed [CompWidth-1:0] acc_e2;
    logic signed [CompWidth-1:0] acc_e12;
    logic signed [CompWidth-1:0] acc_e3;
    logic signed [CompWidth-1:0] acc_e13;
    logic signed [CompWidth-1:0] acc_e23;
    logic signed [CompWidth-1:0] acc_e123;
    logic                        near_match;
  } out_item_t;

  // Gather operand components in basis order
  function automatic mvec_t item_to_mvec(input in_item_t it);
    mvec_t v;
    v[0] = it.x_scalar;
    v[1] = it.x_e1;
    v[2] = it.x_e2;
    v[3] = it.x_e12;
    v[4] = it.x_e3;
    v[5] = it.x_e13;
    v[6] = it.x_e23;
    v[7] = it.x_e123;
    return v;
  endfunction

  // Build a result item from the accumulator and near flag
  function automatic out_item_t mvec_to_item(input mvec_t v, input logic near);
    out_item_t it;
    it.acc_scalar = v[0];
    it.acc_e1     = v[1];
    it.acc_e2     = v[2];
    it.acc_e12    = v[3];
    it.acc_e3     = v[4];
    it.acc_e13    = v[5];
    it.acc_e23    = v[6];
    it.acc_e123   = v[7];
    it.near_match = near;
    return it;
  endfunction

endpackage

// File: rtl/core/mcl3_gp.sv
// Geometric product of two Cl(3,0) multivectors in fixed point.
// Exact signed product sums per blade, floor shift, saturate. Uses mcl3_pkg.
module mcl3_gp import mcl3_pkg::*; (
  input  mvec_t a,
  input  mvec_t b,
  output mvec_t prod
);

  localparam int ProdW = 2 * CompWidth;
  localparam int SumW  = ProdW + 3;

  typedef logic signed [SumW-1:0] sum_t;

  // Sum the 64 signed products into their destination blades
  always_comb begin : gp_sum
    sum_t                    acc [NumBlades];
    sum_t                    sh;
    logic signed [ProdW-1:0] p;
    logic signed [4:0]       e;
    logic [2:0]              dst;
    for (int k = 0; k < NumBlades; k++) begin
      acc[k] = '0;
    end
    for (int i = 0; i < NumBlades; i++) begin
      for (int j = 0; j < NumBlades; j++) begin
        e   = BladeTable[i][j];
        dst = (e < 0) ? 3'(-e - 5'sd1) : 3'(e - 5'sd1);
        p   = $signed(a[i]) * $signed(b[j]);
        if (e < 0) begin
          acc[dst] = acc[dst] - sum_t'(p);
        end else begin
          acc[dst] = acc[dst] + sum_t'(p);
        end
      end
    end
    // Drop fraction bits toward minus infinity and clamp
    for (int k = 0; k < NumBlades; k++) begin
      sh = acc[k] >>> FracBits;
      if (sh > sum_t'(CompMax)) begin
        prod[k] = CompMax;
      end else if (sh < sum_t'(CompMin)) begin
        prod[k] = CompMin;
      end else begin
        prod[k] = comp_t'(sh);
      end
    end
  end

endmodule

// File: rtl/core/mcl3_ops.sv
// Opcode datapath: load, saturating add, reverse, near compare, product select.
// Produces the next accumulator and the near flag. Uses mcl3_pkg.
module mcl3_ops import mcl3_pkg::*; (
  input  logic [OpW-1:0]       op,
  input  mvec_t                acc,
  input  mvec_t                x,
  input  mvec_t                gp,
  input  logic [CompWidth-1:0] tol,
  output mvec_t                acc_nxt,
  output logic                 near
);

  typedef logic signed [CompWidth:0] wide_t;

  mvec_t sum_sat;
  mvec_t rev;
  logic  all_near;

  // Per-component add, reverse and difference magnitude
  always_comb begin : lane_ops
    wide_t s;
    wide_t d;
    wide_t m;
    all_near = 1'b1;
    for (int k = 0; k < NumBlades; k++) begin
      s = wide_t'($signed(acc[k])) + wide_t'($signed(x[k]));
      if (s > wide_t'(CompMax)) begin
        sum_sat[k] = CompMax;
      end else if (s < wide_t'(CompMin)) begin
        sum_sat[k] = CompMin;
      end else begin
        sum_sat[k] = comp_t'(s);
      end

      if (!RevMask[k]) begin
        rev[k] = acc[k];
      end else if (acc[k] == CompMin) begin
        rev[k] = CompMax;
      end else begin
        rev[k] = -$signed(acc[k]);
      end

      d = wide_t'($signed(acc[k])) - wide_t'($signed(x[k]));
      m = (d < 0) ? -d : d;
      if ($unsigned(m) > {1'b0, tol}) begin
        all_near = 1'b0;
      end
    end
  end

  // Select by opcode; unused codes hold the accumulator
  always_comb begin : op_sel
    acc_nxt = acc;
    near    = 1'b0;
    case (op)
      OpLoad:    acc_nxt = x;
      OpAdd:     acc_nxt = sum_sat;
      OpGeoProd: acc_nxt = gp;
      OpReverse: acc_nxt = rev;
      OpNear:    near    = all_near;
      default:   acc_nxt = acc;
    endcase
  end

endmodule

// File: rtl/core/multivector_cl3_alu.sv
// Top level of the Cl(3,0) multivector accumulator ALU.
// Instantiates mcl3_gp and mcl3_ops; uses mcl3_pkg.
//
// Usage:
//   Input channel in_valid / in_stall / in_item carries an opcode and an
//   operand multivector; an item is taken on a clock edge with in_valid high
//   and in_stall low. Each item yields one result on out_valid / out_stall /
//   out_item: the accumulator after the step plus the near flag.
//   cfg_we / cfg_wdata write the near-compare tolerance; write only while idle.
// Timing:
//   Two register stages: an input register, then the result register that
//   also updates the accumulator. A taken item moves from the input register
//   into the result register, where it is taken at an edge with out_stall
//   low. One item per cycle is sustained while out_stall is low; the
//   accumulator feedback through the product array and adder trees is combinational.
// Reset:
//   rst_n low clears both stage valids, the accumulator and the tolerance.
// Stall:
//   While out_stall holds a waiting result, one more item is still taken into
//   the input register; in_stall rises only when both stages are occupied.
module multivector_cl3_alu import mcl3_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_item,
  input  logic                 cfg_we,
  input  logic [CompWidth-1:0] cfg_wdata
);

  logic                 s1_valid_r;
  in_item_t             s1_item_r;
  logic                 out_valid_r;
  out_item_t            out_item_r;
  mvec_t                acc_r;
  mvec_t                acc_nxt;
  logic [CompWidth-1:0] tol_r;
  mvec_t                x_vec;
  mvec_t                gp_res;
  logic                 near;
  logic                 advance;

  assign x_vec    = item_to_mvec(s1_item_r);
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && out_valid_r && out_stall;

  mcl3_gp u_gp (
    .a    (acc_r),
    .b    (x_vec),
    .prod (gp_res)
  );

  mcl3_ops u_ops (
    .op      (s1_item_r.op),
    .acc     (acc_r),
    .x       (x_vec),
    .gp      (gp_res),
    .tol     (tol_r),
    .acc_nxt (acc_nxt),
    .near    (near)
  );

  // Input register: take a new item whenever it is not stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= in_item;
    end
  end

  // Result register: advance on free slot, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= mvec_to_item(acc_nxt, near);
    end
  end

  // Accumulator updates as its item moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (advance) begin
      acc_r <= acc_nxt;
    end
  end

  // Tolerance register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= '0;
    end else if (cfg_we) begin
      tol_r <= cfg_wdata;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// File: rtl/core/mcl3_checker.sv
// Port-level checks for multivector_cl3_alu, attached by bind.
// Watches reset, stall and result channel behaviour. Uses mcl3_pkg.
module mcl3_checker import mcl3_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  // Reset empties both stages
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("out_valid or in_stall set after reset");

  // Input stalls only when a result is waiting and held
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("in_stall without a held result");

  // A held result keeps its item
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("held result item changed or dropped");

endmodule

bind multivector_cl3_alu mcl3_checker u_mcl3_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
